/* hw/rtl/bba_pkg.sv */
package bba_pkg;

    localparam int MAX_BLOCKS    = 4096;
    localparam int BITS_PER_WORD = 8;
    localparam int MAP_WORDS     = MAX_BLOCKS / BITS_PER_WORD;
    localparam int MAP_AW        = $clog2(MAP_WORDS);
    localparam int WORD_W        = BITS_PER_WORD;
    localparam int BIT_W         = $clog2(BITS_PER_WORD);
    localparam int BLK_W         = 12;
    localparam int CNT_W         = 13;

    localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = CNT_W'(4096);
    localparam logic [CNT_W-1:0] MAX_COUNT        = CNT_W'(MAX_BLOCKS);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_FULL        = 2'd1,
        STAT_DOUBLE_FREE = 2'd2,
        STAT_RANGE       = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [BLK_W-1:0]  block_index;
    } req_t;

    typedef struct packed {
        logic [BLK_W-1:0]  result_block;
        status_t           status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_FREE_CHK,
        ST_RESP
    } state_t;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/block_bitmap_allocator_unit.sv */
// channel  dir  handshake               beat
// req      in   req_valid / req_stall   cmd, block_index
// rsp      out  rsp_valid / rsp_stall   result_block, status
// cfg      in   cfg_valid / cfg_ready   total_blocks (13 bits)
//
// After reset the bitmap RAM is cleared one word a cycle, with req stalled.
// Allocate: scans bitmap words from word 0 up to the first with a free bit or the last word;
// the scan reads one RAM word a cycle through its single read port.
// Free: read, check and write back, respond; out of range frees skip the check and respond.
// A finished beat sits in the rsp register, so a new req is taken while rsp is stalled.
module block_bitmap_allocator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  bba_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output bba_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bba_pkg::CNT_W-1:0]   cfg_data
);

    bba_pkg::state_t                 state_reg, state_next;
    logic [bba_pkg::CNT_W-1:0]       total_blocks_reg, total_blocks_next;
    logic [bba_pkg::MAP_AW-1:0]      scan_reg, scan_next;
    logic                            chk_vld_reg, chk_vld_next;
    logic [bba_pkg::MAP_AW-1:0]      chk_addr_reg, chk_addr_next;
    logic [bba_pkg::BLK_W-1:0]       res_block_reg, res_block_next;
    bba_pkg::status_t                res_status_reg, res_status_next;
    bba_pkg::rsp_t                   rsp_reg, rsp_next;
    logic                            rsp_valid_reg, rsp_valid_next;

    logic [bba_pkg::CNT_W-1:0]       count;
    logic [bba_pkg::CNT_W-1:0]       count_m1;
    logic [bba_pkg::MAP_AW-1:0]      last_word;
    logic [bba_pkg::WORD_W-1:0]      word_mask;
    logic [bba_pkg::WORD_W-1:0]      avail;
    logic                            avail_any;
    logic [bba_pkg::BIT_W-1:0]       free_bit;
    logic                            accept;
    logic                            rsp_take;

    logic                            ram_we;
    logic [bba_pkg::MAP_AW-1:0]      ram_waddr;
    logic [bba_pkg::WORD_W-1:0]      ram_wdata;
    logic [bba_pkg::MAP_AW-1:0]      ram_raddr;
    logic [bba_pkg::WORD_W-1:0]      ram_rdata;

    bba_ram #(
        .WIDTH (bba_pkg::WORD_W),
        .DEPTH (bba_pkg::MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count     = (total_blocks_reg > bba_pkg::MAX_COUNT) ? bba_pkg::MAX_COUNT
                                                               : total_blocks_reg;
    assign count_m1  = count - bba_pkg::CNT_W'(1);
    assign last_word = count_m1[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
    assign word_mask = ({1'b0, chk_addr_reg} < count[bba_pkg::CNT_W-1:bba_pkg::BIT_W])
                       ? '1
                       : ~({bba_pkg::WORD_W{1'b1}} << count[bba_pkg::BIT_W-1:0]);
    assign avail     = ~ram_rdata & word_mask;
    assign avail_any = |avail;
    assign free_bit  = bba_pkg::lowest_set(avail);

    assign accept    = req_valid && !req_stall;
    assign rsp_take  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != bba_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                if (scan_reg == bba_pkg::MAP_AW'(bba_pkg::MAP_WORDS - 1))
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == bba_pkg::CMD_ALLOC)
                    begin
                        state_next = (count == '0) ? bba_pkg::ST_RESP : bba_pkg::ST_ALLOC;
                    end
                    else
                    begin
                        state_next = ({1'b0, req.block_index} >= count) ? bba_pkg::ST_RESP
                                                                        : bba_pkg::ST_FREE_CHK;
                    end
                end
            end
            bba_pkg::ST_ALLOC:
            begin
                if (chk_vld_reg && (avail_any || chk_addr_reg == last_word))
                begin
                    state_next = bba_pkg::ST_RESP;
                end
            end
            bba_pkg::ST_FREE_CHK:
            begin
                state_next = bba_pkg::ST_RESP;
            end
            bba_pkg::ST_RESP:
            begin
                if (rsp_take)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_comb
    begin
        total_blocks_next = total_blocks_reg;
        scan_next         = scan_reg;
        chk_vld_next      = chk_vld_reg;
        chk_addr_next     = chk_addr_reg;
        res_block_next    = res_block_reg;
        res_status_next   = res_status_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg;
        ram_we            = 1'b0;
        ram_waddr         = chk_addr_reg;
        ram_wdata         = '0;
        ram_raddr         = scan_reg;

        if (cfg_valid && cfg_ready)
        begin
            total_blocks_next = cfg_data;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = '0;
                scan_next = scan_reg + bba_pkg::MAP_AW'(1);
            end
            bba_pkg::ST_IDLE:
            begin
                ram_raddr = req.block_index[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
                if (accept)
                begin
                    scan_next    = '0;
                    chk_vld_next = 1'b0;
                    if (req.cmd == bba_pkg::CMD_ALLOC)
                    begin
                        res_block_next  = '0;
                        res_status_next = bba_pkg::STAT_FULL;
                    end
                    else
                    begin
                        res_block_next  = req.block_index;
                        res_status_next = bba_pkg::STAT_RANGE;
                    end
                end
            end
            bba_pkg::ST_ALLOC:
            begin
                ram_raddr     = scan_reg;
                scan_next     = scan_reg + bba_pkg::MAP_AW'(1);
                chk_vld_next  = 1'b1;
                chk_addr_next = scan_reg;
                if (chk_vld_reg && avail_any)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = chk_addr_reg;
                    ram_wdata       = ram_rdata | (bba_pkg::WORD_W'(1) << free_bit);
                    res_block_next  = {chk_addr_reg, free_bit};
                    res_status_next = bba_pkg::STAT_OK;
                end
            end
            bba_pkg::ST_FREE_CHK:
            begin
                ram_waddr = res_block_reg[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
                if (ram_rdata[res_block_reg[bba_pkg::BIT_W-1:0]])
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata
                                      & ~(bba_pkg::WORD_W'(1) << res_block_reg[bba_pkg::BIT_W-1:0]);
                    res_status_next = bba_pkg::STAT_OK;
                end
                else
                begin
                    res_status_next = bba_pkg::STAT_DOUBLE_FREE;
                end
            end
            bba_pkg::ST_RESP:
            begin
                if (rsp_take)
                begin
                    rsp_next.result_block = res_block_reg;
                    rsp_next.status       = res_status_reg;
                    rsp_valid_next        = 1'b1;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bba_pkg::ST_CLEAR;
            total_blocks_reg <= bba_pkg::TOTAL_BLOCKS_RST;
            scan_reg         <= '0;
            chk_vld_reg      <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            total_blocks_reg <= total_blocks_next;
            scan_reg         <= scan_next;
            chk_vld_reg      <= chk_vld_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg   <= chk_addr_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != bba_pkg::ST_IDLE)
        else $error("accepted request did not leave idle");

    a_alloc_sets_one: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == bba_pkg::ST_ALLOC)
        |-> $countones(ram_wdata) == $countones(ram_rdata) + 1)
        else $error("allocation write did not set exactly one free bit");

    a_range_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_RESP && res_status_reg == bba_pkg::STAT_RANGE)
        |-> {1'b0, res_block_reg} >= count)
        else $error("range error reported for a managed block");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bba_pkg::ST_CLEAR |-> !rsp_valid_reg)
        else $error("response raised during bitmap clear");

endmodule

/* hw/rtl/bba_ram.sv */
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
